// ----- sv/prf_pkg.sv -----
`timescale 1ns / 1ps
package prf_pkg;

  // Widths fixed by the register map and the stream fields
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned BPP_W   = 4;
  localparam int unsigned SCORE_W = 20;
  localparam int unsigned NUM_FILTERS = 5;

  localparam logic [BPP_W-1:0] BPP_MAX = 4'd8;

  // Configuration register indexes
  localparam logic CFG_ROW_BYTES = 1'b0;
  localparam logic CFG_BPP       = 1'b1;

  // PNG filter type codes
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_ROW_DONE = 3'd1,
    ST_BUSY     = 3'd2,
    ST_BYTE     = 3'd3,
    ST_NONE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_RD2,
    S_CALC,
    S_ACC,
    S_PICK,
    S_FOUT
  } back_state_t;

  // One classified request handed from front to back
  typedef struct packed {
    op_t        op;
    logic       new_image;
    logic [7:0] pixel;
  } item_t;

endpackage

// ----- sv/prf_front.sv -----
`timescale 1ns / 1ps
module prf_front
  import prf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_user,
  input  logic [7:0] in_data,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      item_in;

  // Classify the incoming transaction
  always_comb begin
    item_in.op        = in_user[0] ? OP_FETCH : OP_PUSH;
    item_in.new_image = in_user[1] & ~in_user[0];
    item_in.pixel     = in_data;
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid & in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  // Hold payload in the two-entry queue
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/prf_back.sv -----
`timescale 1ns / 1ps
module prf_back
  import prf_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [IDX_W-1:0] cfg_data,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             o_valid,
  input  logic             o_ready,
  output logic [2:0]       o_status,
  output logic [7:0]       o_byte,
  output logic             o_ift,
  output logic             o_last
);

  localparam int unsigned AW = $clog2(MAX_ROW_BYTES);
  localparam int unsigned XW = (AW > IDX_W) ? AW : IDX_W;

  // Configuration
  logic [IDX_W-1:0] row_bytes;
  logic [BPP_W-1:0] bpp_reg;
  logic [IDX_W-1:0] rb;
  logic [BPP_W-1:0] bpp;

  // Row state
  back_state_t      state, state_next;
  logic             cur_b;
  logic             have_above;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             drain;
  logic [2:0]       chosen;
  logic [SCORE_W-1:0] scores [NUM_FILTERS];

  // Per-item working registers
  op_t              op_q;
  logic [7:0]       pix_q;
  logic [IDX_W-1:0] idx;
  logic [7:0]       xm, am, bm, cm;
  logic [7:0]       res [NUM_FILTERS];

  // Row stores
  logic [7:0]    ram_a [MAX_ROW_BYTES];
  logic [7:0]    ram_b [MAX_ROW_BYTES];
  logic [7:0]    q_a, q_b, q_cur, q_up;
  logic [AW-1:0] addr;
  logic [IDX_W-1:0] addr_idx;
  logic [XW-1:0] addr_ext;
  logic          mem_we;

  // Control from the state machine
  logic       can_emit, emit;
  logic [2:0] e_status;
  logic [7:0] e_byte;
  logic       e_ift, e_last;
  logic       start_push, start_fetch, acc_en, pick_en, fout_en, ft_en;
  logic       row_end, near;
  logic [2:0] best;

  // Datapath values
  logic [7:0] x_v, a_v, b_v, c_v;
  logic [8:0] avg_sum;
  logic signed [9:0] pa, pb, pc, p_ac, p_bc;
  logic [7:0] paeth_v;

  // Effective register values
  always_comb begin
    if (row_bytes == '0) begin
      rb = IDX_W'(1);
    end else if (32'(row_bytes) > MAX_ROW_BYTES) begin
      rb = IDX_W'(MAX_ROW_BYTES);
    end else begin
      rb = row_bytes;
    end
    if (bpp_reg == '0) begin
      bpp = BPP_W'(1);
    end else if (bpp_reg > BPP_MAX) begin
      bpp = BPP_MAX;
    end else begin
      bpp = bpp_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes <= IDX_W'(4096);
      bpp_reg   <= BPP_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_BYTES: row_bytes <= cfg_data;
        CFG_BPP:       bpp_reg   <= cfg_data[BPP_W-1:0];
        default:       row_bytes <= row_bytes;
      endcase
    end
  end

  // Memory access: byte and its left neighbour on consecutive cycles
  assign addr_idx = (state == S_RD1) ? (idx - IDX_W'(bpp)) : idx;
  assign addr_ext = XW'(addr_idx);
  assign addr     = addr_ext[AW-1:0];
  assign mem_we   = (state == S_RD2) && (op_q == OP_PUSH);

  always_ff @(posedge clk) begin
    if (mem_we && !cur_b) begin
      ram_a[addr] <= pix_q;
    end
    q_a <= ram_a[addr];
  end

  always_ff @(posedge clk) begin
    if (mem_we && cur_b) begin
      ram_b[addr] <= pix_q;
    end
    q_b <= ram_b[addr];
  end

  assign q_cur = cur_b ? q_b : q_a;
  assign q_up  = cur_b ? q_a : q_b;

  // Predictors and residues
  always_comb begin
    near    = (idx >= IDX_W'(bpp));
    x_v     = (op_q == OP_PUSH) ? pix_q : xm;
    a_v     = near ? am : 8'd0;
    b_v     = have_above ? bm : 8'd0;
    c_v     = (have_above && near) ? cm : 8'd0;
    avg_sum = {1'b0, a_v} + {1'b0, b_v};
    p_bc    = $signed({2'b00, b_v}) - $signed({2'b00, c_v});
    p_ac    = $signed({2'b00, a_v}) - $signed({2'b00, c_v});
    pa      = (p_bc < 0) ? -p_bc : p_bc;
    pb      = (p_ac < 0) ? -p_ac : p_ac;
    pc      = ((p_ac + p_bc) < 0) ? -(p_ac + p_bc) : (p_ac + p_bc);
    if (pa <= pb && pa <= pc) begin
      paeth_v = a_v;
    end else if (pb <= pc) begin
      paeth_v = b_v;
    end else begin
      paeth_v = c_v;
    end
  end

  // Lowest score, earliest filter on ties
  always_comb begin
    best = FILT_NONE;
    for (int f = 1; f < NUM_FILTERS; f++) begin
      if (scores[f] < scores[best]) begin
        best = 3'(f);
      end
    end
  end

  assign row_end  = ({1'b0, wr_idx} + 14'd1) >= {1'b0, rb};
  assign can_emit = !o_valid || o_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencing
  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    emit        = 1'b0;
    e_status    = ST_ACCEPTED;
    e_byte      = 8'd0;
    e_ift       = 1'b0;
    e_last      = 1'b0;
    start_push  = 1'b0;
    start_fetch = 1'b0;
    acc_en      = 1'b0;
    pick_en     = 1'b0;
    fout_en     = 1'b0;
    ft_en       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.op == OP_PUSH) begin
            if (drain) begin
              if (can_emit) begin
                q_pop    = 1'b1;
                emit     = 1'b1;
                e_status = ST_BUSY;
              end
            end else begin
              q_pop      = 1'b1;
              start_push = 1'b1;
              state_next = S_RD0;
            end
          end else begin
            if (!drain) begin
              if (can_emit) begin
                q_pop    = 1'b1;
                emit     = 1'b1;
                e_status = ST_NONE;
              end
            end else if (rd_idx == '0) begin
              if (can_emit) begin
                q_pop    = 1'b1;
                emit     = 1'b1;
                ft_en    = 1'b1;
                e_status = ST_BYTE;
                e_byte   = {5'd0, chosen};
                e_ift    = 1'b1;
              end
            end else begin
              q_pop       = 1'b1;
              start_fetch = 1'b1;
              state_next  = S_RD0;
            end
          end
        end
      end
      S_RD0:  state_next = S_RD1;
      S_RD1:  state_next = S_RD2;
      S_RD2:  state_next = S_CALC;
      S_CALC: state_next = (op_q == OP_PUSH) ? S_ACC : S_FOUT;
      S_ACC: begin
        if (row_end) begin
          acc_en     = 1'b1;
          state_next = S_PICK;
        end else if (can_emit) begin
          acc_en     = 1'b1;
          emit       = 1'b1;
          e_status   = ST_ACCEPTED;
          state_next = S_IDLE;
        end
      end
      S_PICK: begin
        if (can_emit) begin
          pick_en    = 1'b1;
          emit       = 1'b1;
          e_status   = ST_ROW_DONE;
          state_next = S_IDLE;
        end
      end
      S_FOUT: begin
        if (can_emit) begin
          fout_en    = 1'b1;
          emit       = 1'b1;
          e_status   = ST_BYTE;
          e_byte     = res[chosen];
          e_last     = (rd_idx >= rb);
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Item registers and fetched neighbours
  always_ff @(posedge clk) begin
    if (start_push || start_fetch) begin
      op_q  <= q_item.op;
      pix_q <= q_item.pixel;
    end
    if (start_push) begin
      idx <= q_item.new_image ? '0 : wr_idx;
    end else if (start_fetch) begin
      idx <= rd_idx - IDX_W'(1);
    end
    if (state == S_RD1) begin
      xm <= q_cur;
      bm <= q_up;
    end
    if (state == S_RD2) begin
      am <= q_cur;
      cm <= q_up;
    end
    if (state == S_CALC) begin
      res[FILT_NONE]  <= x_v;
      res[FILT_SUB]   <= x_v - a_v;
      res[FILT_UP]    <= x_v - b_v;
      res[FILT_AVG]   <= x_v - avg_sum[8:1];
      res[FILT_PAETH] <= x_v - paeth_v;
    end
  end

  // Row control state and scores
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_b      <= 1'b0;
      have_above <= 1'b0;
      wr_idx     <= '0;
      rd_idx     <= '0;
      drain      <= 1'b0;
      chosen     <= FILT_NONE;
      for (int f = 0; f < NUM_FILTERS; f++) begin
        scores[f] <= '0;
      end
    end else begin
      if (start_push && q_item.new_image) begin
        have_above <= 1'b0;
        wr_idx     <= '0;
        for (int f = 0; f < NUM_FILTERS; f++) begin
          scores[f] <= '0;
        end
      end
      if (acc_en) begin
        for (int f = 0; f < NUM_FILTERS; f++) begin
          logic [7:0]       mag;
          logic [SCORE_W:0] sum;
          mag = res[f][7] ? (8'd0 - res[f]) : res[f];
          sum = {1'b0, scores[f]} + (SCORE_W+1)'(mag);
          scores[f] <= sum[SCORE_W] ? {SCORE_W{1'b1}} : sum[SCORE_W-1:0];
        end
        if (!row_end) begin
          wr_idx <= wr_idx + IDX_W'(1);
        end
      end
      if (pick_en) begin
        chosen <= best;
        drain  <= 1'b1;
        rd_idx <= '0;
      end
      if (ft_en) begin
        rd_idx <= IDX_W'(1);
      end
      if (fout_en) begin
        if (rd_idx >= rb) begin
          drain      <= 1'b0;
          rd_idx     <= '0;
          wr_idx     <= '0;
          cur_b      <= ~cur_b;
          have_above <= 1'b1;
          for (int f = 0; f < NUM_FILTERS; f++) begin
            scores[f] <= '0;
          end
        end else begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (o_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_status <= e_status;
      o_byte   <= e_byte;
      o_ift    <= e_ift;
      o_last   <= e_last;
    end
  end

endmodule

// ----- sv/png_adaptive_row_filter_core.sv -----
`timescale 1ns / 1ps
// PNG adaptive row filter: raw bytes are pushed (tuser[0]=0) into one of two
// row stores while the other holds the row above; the None, Sub, Up, Average
// and Paeth residues are scored as they arrive, and at row end the filter with
// the lowest sum of absolute residues is chosen (earliest on ties). Fetches
// (tuser[0]=1) then return the filter type byte followed by the row's
// residues. Every transaction gives exactly one result transaction. Each is
// finished before the next is taken. A rejected push, an empty fetch or the
// filter type byte is answered from the idle state; each residue needs the
// byte and its left neighbour from both single-port row stores, read one
// after the other, then the residues are formed and a push scores them. A
// two-entry queue ahead of the engine accepts until full while it works.
module png_adaptive_row_filter_core
  import prf_pkg::*;
#(
  parameter int unsigned MAX_ROW_BYTES = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [IDX_W-1:0] cfg_data,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [7:0] pixel_byte
  input  logic [1:0]       s_axis_tuser,  // [0] kind, [1] new_image
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
  output logic [3:0]       m_axis_tuser,  // [2:0] status, [3] is_filter_type
  output logic             m_axis_tlast
);

  logic       q_valid;
  item_t      q_item;
  logic       q_pop;
  logic [2:0] o_status;
  logic       o_ift;

  prf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_user  (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  prf_back #(
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .o_valid   (m_axis_tvalid),
    .o_ready   (m_axis_tready),
    .o_status  (o_status),
    .o_byte    (m_axis_tdata),
    .o_ift     (o_ift),
    .o_last    (m_axis_tlast)
  );

  assign m_axis_tuser = {o_ift, o_status};

endmodule

// ----- sv/prf_checker.sv -----
`timescale 1ns / 1ps
module prf_checker
  import prf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [3:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Row end only on a residue byte
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tuser[2:0] == ST_BYTE && !m_axis_tuser[3])
    else $error("tlast on a non-residue result");

  // Filter type byte carries a valid code
  a_type: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[3] |->
      m_axis_tuser[2:0] == ST_BYTE && m_axis_tdata <= 8'(FILT_PAETH))
    else $error("bad filter type byte");

  // Only byte results carry data
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2:0] != ST_BYTE |->
      m_axis_tdata == 8'd0 && m_axis_tuser[2:0] <= ST_NONE)
    else $error("data on a status-only result");

endmodule

bind png_adaptive_row_filter_core prf_checker u_prf_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/sv/png_adaptive_row_filter_core_tb.sv -----
`timescale 1ns / 1ps
module png_adaptive_row_filter_core_tb;
  import prf_pkg::*;

  localparam int unsigned ROW_MAX = 4096;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned SCORE_SAT = 20'hFFFFF;
  localparam int unsigned ITEM_TARGET = 1900;

  typedef struct packed {
    op_t        op;
    logic       new_image;
    logic [7:0] pixel;
  } req_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] out_byte;
    logic       is_type;
    logic       last;
  } resp_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [IDX_W-1:0] cfg_data;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;   // [7:0] pixel_byte
  logic [1:0]       s_axis_tuser;   // [0] kind, [1] new_image
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [7:0]       m_axis_tdata;   // [7:0] out_byte
  logic [3:0]       m_axis_tuser;   // [2:0] status, [3] is_filter_type
  logic             m_axis_tlast;

  png_adaptive_row_filter_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
  );

  // Predictor state
  logic [7:0]  row_a [ROW_MAX];
  logic [7:0]  row_b [ROW_MAX];
  logic        cur_b, have_above, draining;
  int unsigned wr_idx, rd_idx;
  logic [2:0]  best_filter;
  int unsigned scores [NUM_FILTERS];
  int unsigned row_len_reg, bpp_reg;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int unsigned errors, cycles;
  int unsigned n_items;
  int unsigned in_gap, out_gap;
  logic s_axis_tready_seen;

  function automatic int unsigned row_len_eff();
    if (row_len_reg == 0) return 1;
    if (row_len_reg > ROW_MAX) return ROW_MAX;
    return row_len_reg;
  endfunction

  function automatic int unsigned bpp_eff();
    if (bpp_reg == 0) return 1;
    if (bpp_reg > 8) return 8;
    return bpp_reg;
  endfunction

  function automatic int unsigned abs_i(int x);
    return (x < 0) ? -x : x;
  endfunction

  // Residue of byte i of the current row under filter f
  function automatic logic [7:0] filter_residue(logic [2:0] f, int unsigned i);
    int unsigned bpp, x, a, b, c, pred, pa, pb, pc;
    int p;
    bpp = bpp_eff();
    x = cur_b ? row_b[i] : row_a[i];
    a = (i >= bpp) ? (cur_b ? row_b[i-bpp] : row_a[i-bpp]) : 0;
    b = have_above ? (cur_b ? row_a[i] : row_b[i]) : 0;
    c = (have_above && i >= bpp) ? (cur_b ? row_a[i-bpp] : row_b[i-bpp]) : 0;
    case (f)
      FILT_SUB:  pred = a;
      FILT_UP:   pred = b;
      FILT_AVG:  pred = (a + b) >> 1;
      FILT_PAETH: begin
        p = int'(a) + int'(b) - int'(c);
        pa = abs_i(p - int'(a));
        pb = abs_i(p - int'(b));
        pc = abs_i(p - int'(c));
        if (pa <= pb && pa <= pc) pred = a;
        else if (pb <= pc) pred = b;
        else pred = c;
      end
      default:   pred = 0;
    endcase
    return 8'(x - pred);
  endfunction

  // Advance the predictor by one request
  function automatic resp_t predict_filter_step(req_t r);
    resp_t o;
    int unsigned rb, mag, s;
    logic [7:0] res;
    o = '0;
    rb = row_len_eff();
    if (r.op == OP_PUSH) begin
      if (draining) begin
        o.status = ST_BUSY;
      end else begin
        if (r.new_image) begin
          have_above = 1'b0;
          wr_idx = 0;
          foreach (scores[k]) scores[k] = 0;
        end
        if (cur_b) row_b[wr_idx] = r.pixel;
        else row_a[wr_idx] = r.pixel;
        for (int f = 0; f < NUM_FILTERS; f++) begin
          res = filter_residue(3'(f), wr_idx);
          mag = (res < 128) ? res : 256 - res;
          s = scores[f] + mag;
          scores[f] = (s > SCORE_SAT) ? SCORE_SAT : s;
        end
        if (wr_idx + 1 >= rb) begin
          best_filter = FILT_NONE;
          for (int f = 1; f < NUM_FILTERS; f++)
            if (scores[f] < scores[best_filter]) best_filter = 3'(f);
          draining = 1'b1;
          rd_idx = 0;
          o.status = ST_ROW_DONE;
        end else begin
          wr_idx = wr_idx + 1;
          o.status = ST_ACCEPTED;
        end
      end
    end else if (!draining) begin
      o.status = ST_NONE;
    end else begin
      o.status = ST_BYTE;
      if (rd_idx == 0) begin
        o.out_byte = {5'd0, best_filter};
        o.is_type = 1'b1;
        rd_idx = 1;
      end else begin
        o.out_byte = filter_residue(best_filter, rd_idx - 1);
        if (rd_idx >= rb) begin
          o.last = 1'b1;
          draining = 1'b0;
          rd_idx = 0;
          wr_idx = 0;
          cur_b = ~cur_b;
          have_above = 1'b1;
          foreach (scores[k]) scores[k] = 0;
        end else begin
          rd_idx = rd_idx + 1;
        end
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle counter and watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Driver: present queued transactions, idle at random between them
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready_seen) begin
      if (in_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        req_t r;
        resp_t p;
        r = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= r.pixel;
        s_axis_tuser <= {r.new_image, r.op};
        p = predict_filter_step(r);
        expected_resps = {expected_resps, p};
        in_gap <= gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Note the input handshake at the rising edge for the driver
  always @(posedge clk) s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;

  // Receiver stalls
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_gap <= 0;
    end else if (out_gap != 0) begin
      m_axis_tready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_resps.size() == 0) begin
        $display("unexpected result transaction at cycle %0d", cycles);
        errors++;
      end else begin
        resp_t e;
        e = expected_resps.pop_front();
        if (m_axis_tuser[2:0] !== e.status) report_mismatch("status", m_axis_tuser[2:0], e.status);
        if (m_axis_tdata !== e.out_byte) report_mismatch("out_byte", m_axis_tdata, e.out_byte);
        if (m_axis_tuser[3] !== e.is_type) report_mismatch("is_filter_type", m_axis_tuser[3], e.is_type);
        if (m_axis_tlast !== e.last) report_mismatch("last_of_row", m_axis_tlast, e.last);
      end
    end
  end

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_resps.size() != 0 || s_axis_tvalid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= IDX_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ROW_BYTES) row_len_reg = val & 13'h1FFF;
    else bpp_reg = val & 4'hF;
  endtask

  function automatic void add_req(op_t op, logic ni, logic [7:0] px);
    req_t r;
    r.op = op; r.new_image = ni; r.pixel = px;
    pending_reqs = {pending_reqs, r};
    n_items++;
  endfunction

  // Queue one row of patterned or random pushes with drain fetches; stray fetches land
  // before the row completes and stray pushes while the row still drains
  function automatic void add_row(int unsigned len, logic first, int unsigned style);
    for (int unsigned i = 0; i < len; i++) begin
      logic [7:0] px;
      case (style)
        0: px = 8'($urandom);
        1: px = 8'(i * 3);
        2: px = (i % 2) ? 8'hFF : 8'h00;
        default: px = 8'($urandom_range(100, 140));
      endcase
      add_req(OP_PUSH, first && i == 0, px);
      if (i + 1 < len && $urandom_range(0, 29) == 0)
        add_req(OP_FETCH, 1'($urandom), 8'($urandom));
    end
    for (int unsigned i = 0; i <= len; i++) begin
      add_req(OP_FETCH, 1'($urandom), 8'($urandom));
      if (i < len && $urandom_range(0, 19) == 0)
        add_req(OP_PUSH, 1'($urandom), 8'($urandom));
    end
  endfunction

  initial begin
    int unsigned len;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = CFG_ROW_BYTES; cfg_data = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    errors = 0; cycles = 0; n_items = 0;
    in_gap = 0; out_gap = 0;
    cur_b = 0; have_above = 0; draining = 0; wr_idx = 0; rd_idx = 0;
    best_filter = FILT_NONE;
    foreach (scores[k]) scores[k] = 0;
    row_len_reg = 4096; bpp_reg = 4;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty fetch, then small rows of extremes with reject cases
    write_reg(CFG_ROW_BYTES, 4);
    write_reg(CFG_BPP, 1);
    add_req(OP_FETCH, 1'b1, 8'hFF);
    add_req(OP_PUSH, 1'b1, 8'h00);
    add_req(OP_PUSH, 1'b0, 8'hFF);
    add_req(OP_PUSH, 1'b0, 8'h80);
    add_req(OP_PUSH, 1'b0, 8'h7F);
    add_req(OP_PUSH, 1'b1, 8'h01);
    for (int i = 0; i < 5; i++) add_req(OP_FETCH, 1'b0, 8'h00);
    add_req(OP_PUSH, 1'b0, 8'h10);
    add_req(OP_PUSH, 1'b1, 8'hF0);
    add_req(OP_PUSH, 1'b0, 8'h0F);
    add_req(OP_PUSH, 1'b0, 8'hAA);
    add_req(OP_PUSH, 1'b0, 8'h55);
    for (int i = 0; i < 6; i++) add_req(OP_FETCH, 1'b0, 8'h00);
    wait_idle();

    // Zero register values act as one
    write_reg(CFG_ROW_BYTES, 0);
    write_reg(CFG_BPP, 0);
    add_row(1, 1'b1, 0);
    add_row(1, 1'b0, 0);
    wait_idle();

    // Random phases over a spread of row lengths, bpp values and pixel patterns
    while (n_items < ITEM_TARGET) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
      write_reg(CFG_ROW_BYTES, len);
      write_reg(CFG_BPP, $urandom_range(0, 15));
      add_row(len, 1'b1, $urandom_range(0, 3));
      for (int k = $urandom_range(1, 4); k > 0; k--) add_row(len, 1'b0, $urandom_range(0, 3));
      wait_idle();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/prf_pkg.sv
sv/prf_front.sv
sv/prf_back.sv
sv/png_adaptive_row_filter_core.sv
sv/prf_checker.sv
tb/sv/png_adaptive_row_filter_core_tb.sv
